// File: rtl/aslr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aslr_pkg
// Shared types and codes for the active set list with rank compaction.
// ----------------------------------------------------------------------------
package aslr_pkg;

  // request codes
  localparam logic [1:0] REQ_QUERY = 2'd0;
  localparam logic [1:0] REQ_DEACT = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INACTIVE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  // request beat
  typedef struct packed {
    logic [1:0]  req_type;
    logic [10:0] argument;
  } in_t;

  // result beat
  typedef struct packed {
    logic [1:0]  status;
    logic        is_active_flag;
    logic [10:0] next_item;
    logic [10:0] previous_item;
    logic        has_next_flag;
    logic        has_previous_flag;
    logic [10:0] item_rank;
    logic [10:0] active_total;
    logic [10:0] first_item;
  } out_t;

endpackage
`default_nettype wire

// File: rtl/aslr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aslr_ram
// Simple dual-port memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module aslr_ram #(
  parameter int DEPTH = 1025,
  parameter int WIDTH = 11
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/active_set_list_with_rank_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// active_set_list_with_rank_top
// Ordered set of active items kept as an array-indexed doubly linked list,
// with a dense rank table compacted on every successful deactivate.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+------------------------
//   in       | input     | in_valid/in_stall  | in_data (aslr_pkg::in_t)
//   out      | output    | out_valid/out_stall| out_data (aslr_pkg::out_t)
//   cfg      | input     | cfg_we             | cfg_data (argument_count)
//
// Query of an in-range item: S_READ, S_LOOK, then S_EMIT loads the result
// register. Deactivate of an active item: S_READ, S_LOOK, S_UNLINK1,
// S_UNLINK2, then a walk in S_SHIFT over the k later ranks moved down (one
// memory read and one write per cycle), then S_EMIT. Initialize: one table
// entry written per cycle. After reset a clearing pass runs with in_stall
// high. One request at a time; a finished result waits in the output
// register while the next beat is taken.
// ----------------------------------------------------------------------------
module active_set_list_with_rank_top
  import aslr_pkg::*;
#(
  parameter int MAX_ITEMS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_we,
  input  wire logic [10:0] cfg_data
);

  localparam int DEPTH = MAX_ITEMS + 1;
  localparam int IW    = $clog2(DEPTH);
  localparam int RW    = (IW > 11) ? IW : 11;
  localparam int CW    = IW + 1;
  localparam logic [IW-1:0] MAX_IDX = IW'(MAX_ITEMS);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_FILL    = 8'b0000_0010,
    S_READ    = 8'b0000_0100,
    S_LOOK    = 8'b0000_1000,
    S_UNLINK1 = 8'b0001_0000,
    S_UNLINK2 = 8'b0010_0000,
    S_SHIFT   = 8'b0100_0000,
    S_EMIT    = 8'b1000_0000
  } state_t;

  state_t        state;
  logic [RW-1:0] arg_count;
  logic [IW-1:0] head;
  logic [IW-1:0] count;
  logic [IW-1:0] fill_n;
  logic [IW-1:0] fi;
  logic          fill_emit;
  logic [IW-1:0] a_reg;
  logic          is_deact;
  logic [IW-1:0] p_reg;
  logic [IW-1:0] n_reg;
  logic [IW-1:0] r_reg;
  logic [CW-1:0] sh_i;
  logic          pend;
  logic [IW-1:0] pend_idx;
  out_t          res;

  logic          prev_we,  next_we,  rank_we,  iar_we;
  logic [IW-1:0] prev_waddr, next_waddr, rank_waddr, iar_waddr;
  logic [IW-1:0] prev_wdata, next_wdata, rank_wdata, iar_wdata;
  logic [IW-1:0] prev_rdata, next_rdata, rank_rdata, iar_rdata;
  logic [IW-1:0] iar_raddr;

  logic          in_fire;
  logic          fill_in;
  logic [IW-1:0] n_sat;
  logic          sh_issue;
  logic          self_p, self_n;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign fill_in  = (fi != '0) && (fi <= fill_n);
  assign n_sat    = (32'(arg_count) > MAX_ITEMS) ? MAX_IDX : IW'(arg_count);
  assign sh_issue = (sh_i <= CW'(count));
  assign self_p   = (p_reg == a_reg);
  assign self_n   = (n_reg == a_reg);
  assign iar_raddr = IW'(sh_i);

  // table memories
  aslr_ram #(.DEPTH(DEPTH), .WIDTH(IW)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .raddr(a_reg), .rdata(prev_rdata)
  );
  aslr_ram #(.DEPTH(DEPTH), .WIDTH(IW)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .raddr(a_reg), .rdata(next_rdata)
  );
  aslr_ram #(.DEPTH(DEPTH), .WIDTH(IW)) u_rank (
    .clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
    .raddr(a_reg), .rdata(rank_rdata)
  );
  aslr_ram #(.DEPTH(DEPTH), .WIDTH(IW)) u_iar (
    .clk(clk), .we(iar_we), .waddr(iar_waddr), .wdata(iar_wdata),
    .raddr(iar_raddr), .rdata(iar_rdata)
  );

  // memory write ports, one write per table per cycle
  always_comb begin
    prev_we = 1'b0; prev_waddr = a_reg; prev_wdata = '0;
    next_we = 1'b0; next_waddr = a_reg; next_wdata = '0;
    rank_we = 1'b0; rank_waddr = a_reg; rank_wdata = '0;
    iar_we  = 1'b0; iar_waddr  = fi;    iar_wdata  = fi;
    unique case (state)
      S_FILL: begin
        prev_we = 1'b1; prev_waddr = fi;
        next_we = 1'b1; next_waddr = fi;
        rank_we = 1'b1; rank_waddr = fi;
        iar_we  = 1'b1;
        if (fill_in) begin
          prev_wdata = (fi == IW'(1)) ? fi : fi - IW'(1);
          next_wdata = (fi == fill_n) ? fi : fi + IW'(1);
          rank_wdata = fi;
        end
      end
      S_UNLINK1: begin
        rank_we = 1'b1;
        if (self_p && !self_n) begin
          prev_we = 1'b1; prev_waddr = n_reg; prev_wdata = n_reg;
        end else if (!self_p && self_n) begin
          next_we = 1'b1; next_waddr = p_reg; next_wdata = p_reg;
        end else if (!self_p && !self_n) begin
          prev_we = 1'b1; prev_waddr = n_reg; prev_wdata = p_reg;
          next_we = 1'b1; next_waddr = p_reg; next_wdata = n_reg;
        end
      end
      S_UNLINK2: begin
        prev_we = 1'b1;
        next_we = 1'b1;
      end
      S_SHIFT: begin
        // move the item read last cycle one rank down
        if (pend) begin
          iar_we     = 1'b1;
          iar_waddr  = pend_idx - IW'(1);
          iar_wdata  = iar_rdata;
          rank_we    = 1'b1;
          rank_waddr = iar_rdata;
          rank_wdata = pend_idx - IW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      arg_count <= RW'(MAX_ITEMS);
    end else if (cfg_we) begin
      arg_count <= RW'(cfg_data);
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_FILL;
      fi        <= '0;
      fill_n    <= '0;
      fill_emit <= 1'b0;
      head      <= '0;
      count     <= '0;
      pend      <= 1'b0;
    end else begin
      pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            a_reg    <= IW'(in_data.argument);
            is_deact <= (in_data.req_type == REQ_DEACT);
            if (in_data.req_type == REQ_INIT) begin
              res       <= '0;
              fill_n    <= n_sat;
              fi        <= '0;
              fill_emit <= 1'b1;
              state     <= S_FILL;
            end else if ((in_data.argument == '0) ||
                         (32'(in_data.argument) > MAX_ITEMS)) begin
              res   <= '{status: ST_RANGE, active_total: 11'(count),
                         first_item: 11'(head), default: '0};
              state <= S_EMIT;
            end else begin
              res   <= '0;
              state <= S_READ;
            end
          end
        end
        S_FILL: begin
          fi <= fi + IW'(1);
          if (fi == MAX_IDX) begin
            head <= (fill_n != '0) ? IW'(1) : '0;
            count <= fill_n;
            res.active_total <= 11'(fill_n);
            res.first_item   <= (fill_n != '0) ? 11'd1 : 11'd0;
            state <= fill_emit ? S_EMIT : S_IDLE;
          end
        end
        S_READ: begin
          state <= S_LOOK;
        end
        S_LOOK: begin
          p_reg <= prev_rdata;
          n_reg <= next_rdata;
          r_reg <= rank_rdata;
          res.active_total <= 11'(count);
          res.first_item   <= 11'(head);
          if (prev_rdata == '0 && next_rdata == '0) begin
            res.status <= ST_INACTIVE;
            state      <= S_EMIT;
          end else if (is_deact) begin
            state <= S_UNLINK1;
          end else begin
            res.is_active_flag    <= 1'b1;
            res.next_item         <= 11'(next_rdata);
            res.previous_item     <= 11'(prev_rdata);
            res.has_next_flag     <= (next_rdata != a_reg);
            res.has_previous_flag <= (prev_rdata != a_reg);
            res.item_rank         <= 11'(rank_rdata);
            state                 <= S_EMIT;
          end
        end
        S_UNLINK1: begin
          if (self_p && self_n) begin
            head <= '0;
          end else if (self_p) begin
            head <= n_reg;
          end
          sh_i  <= CW'(r_reg) + CW'(1);
          state <= S_UNLINK2;
        end
        S_UNLINK2: begin
          state <= S_SHIFT;
        end
        S_SHIFT: begin
          // read the next rank entry while the previous one is written back
          if (sh_issue) begin
            pend     <= 1'b1;
            pend_idx <= IW'(sh_i);
            sh_i     <= sh_i + CW'(1);
          end else if (!pend) begin
            count            <= count - IW'(1);
            res.active_total <= 11'(count - IW'(1));
            res.first_item   <= 11'(head);
            state            <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_valid || !out_stall)) begin
      out_data <= res;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= MAX_ITEMS)
    else $error("active count above item limit");

  a_head_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((head == '0) == (count == '0)))
    else $error("list head and active count disagree");

  a_pend_shift: assert property (@(posedge clk) disable iff (rst)
    pend |-> (state == S_SHIFT && pend_idx != '0))
    else $error("rank write-back outside the shift walk");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != ST_OK) |->
      (!out_data.is_active_flag && out_data.item_rank == 11'd0))
    else $error("failed request reports item fields");

  a_active_rank: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.is_active_flag) |-> (out_data.item_rank != 11'd0))
    else $error("active item reported with rank zero");
`endif

endmodule
`default_nettype wire
